@@ rtl/core/tccw_pkg.sv @@
// package: types, constants and code tables for the text console character writer
`default_nettype none
package tccw_pkg;
    localparam int NUM_COLS = 40;
    localparam int NUM_ROWS = 25;
    localparam int NUM_CELLS = NUM_COLS * NUM_ROWS;
    localparam int CW = $clog2(NUM_COLS);
    localparam int RW = $clog2(NUM_ROWS);
    localparam int AW = $clog2(NUM_CELLS);
    localparam int DW = 12;

    localparam logic [7:0] CH_RETURN = 8'h0D;
    localparam logic [7:0] CH_DELETE = 8'h14;
    localparam logic [7:0] CH_CLEAR  = 8'h93;
    localparam logic [7:0] CH_HOME   = 8'h13;
    localparam logic [7:0] CH_RVS_ON = 8'h12;
    localparam logic [7:0] CH_RVS_OFF = 8'h92;
    localparam logic [7:0] CH_DOWN   = 8'h11;
    localparam logic [7:0] CH_UP     = 8'h91;
    localparam logic [7:0] CH_RIGHT  = 8'h1D;
    localparam logic [7:0] CH_LEFT   = 8'h9D;
    localparam logic [7:0] RVS_BIT   = 8'h80;
    localparam logic [7:0] SPACE     = 8'd32;
    localparam logic [3:0] START_COLOR_RESET = 4'd14;
    localparam logic [1:0] REG_START_COLOR = 2'd0;

    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
        logic       from_keyboard;
        logic [9:0] cell_offset;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_code;
        logic [3:0] cell_color;
        logic [5:0] cursor_col;
        logic [4:0] cursor_row;
        logic       reverse_on;
        logic [3:0] ink_color;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic          load;      // latch the input item and decode it
        logic          fill_wr;   // write fill cell at sweep address
        logic          copy_rd;   // read cell at sweep address plus one row
        logic          copy_wr;   // write read data at sweep address
        logic          cell_wr;   // write char cell at cursor
        logic          look_rd;   // read cell at cell offset
        logic          out_load;  // capture result
        logic [AW-1:0] addr;
        logic          finish;    // apply cursor and mode update
        logic          scroll_fix;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic is_clear;
        logic is_cell;
        logic need_scroll;
    } dp_stat_t;

    function automatic logic [4:0] ink_code(input logic [7:0] c);
        logic [4:0] r;
        case (c)
            8'd144: r = 5'h10; 8'd5: r = 5'h11; 8'd28: r = 5'h12; 8'd159: r = 5'h13;
            8'd156: r = 5'h14; 8'd30: r = 5'h15; 8'd31: r = 5'h16; 8'd158: r = 5'h17;
            8'd129: r = 5'h18; 8'd149: r = 5'h19; 8'd150: r = 5'h1A; 8'd151: r = 5'h1B;
            8'd152: r = 5'h1C; 8'd153: r = 5'h1D; 8'd154: r = 5'h1E; 8'd155: r = 5'h1F;
            default: r = 5'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] to_screen(input logic [7:0] c);
        logic [7:0] r;
        if (c < 8'h20) r = c + 8'h80;
        else if (c < 8'h40) r = c;
        else if (c < 8'h60) r = c - 8'h40;
        else if (c < 8'h80) r = c - 8'h20;
        else if (c < 8'hA0) r = c + 8'h40;
        else if (c < 8'hC0) r = c - 8'h40;
        else if (c < 8'hFF) r = c - 8'h80;
        else r = 8'h5E;
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/tccw_ram.sv @@
// generic ram with one write port and one registered read port
`default_nettype none
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/tccw_datapath.sv @@
// datapath: item decode, cursor and mode registers, screen store
`default_nettype none
module tccw_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tccw_pkg::in_item_t  in_item,
    input  wire tccw_pkg::dp_cmd_t   cmd,
    input  wire logic                cfg_wr,
    input  wire logic [3:0]          cfg_color,
    output tccw_pkg::dp_stat_t       stat,
    output tccw_pkg::out_item_t      out_item
);
    localparam int CW = tccw_pkg::CW;
    localparam int RW = tccw_pkg::RW;
    localparam int AW = tccw_pkg::AW;
    localparam logic [CW-1:0] LAST_COL = CW'(tccw_pkg::NUM_COLS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(tccw_pkg::NUM_ROWS - 1);
    localparam logic [AW-1:0] ROW_STEP = AW'(tccw_pkg::NUM_COLS);

    tccw_pkg::in_item_t item_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          rvs_reg, rvs_next;
    logic [3:0]    ink_reg, ink_next;
    logic [tccw_pkg::NUM_ROWS-1:0] cont_reg, cont_next;
    logic [7:0]    wcode;
    logic [7:0]    wcode_reg;
    logic          scroll_reg;
    logic [CW-1:0] wcol_reg;
    logic [RW-1:0] wrow_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [tccw_pkg::DW-1:0] wdata, rdata;

    logic [7:0] c;
    logic [4:0] ink;
    logic       in_rng;

    function automatic logic [7:0] to_cell(input logic [7:0] b, input logic r);
        return tccw_pkg::to_screen(b) | (r ? tccw_pkg::RVS_BIT : 8'h00);
    endfunction

    assign c = item_reg.char_code;
    assign ink = tccw_pkg::ink_code(c);
    assign in_rng = item_reg.cell_offset < 10'(tccw_pkg::NUM_CELLS);

    always_comb
    begin
        stat.is_read = item_reg.action;
        stat.is_clear = !item_reg.action && c == tccw_pkg::CH_CLEAR;
        stat.is_cell = !item_reg.action && (c == tccw_pkg::CH_DELETE ||
            !(c == tccw_pkg::CH_RETURN || c == tccw_pkg::CH_CLEAR || c == tccw_pkg::CH_HOME ||
              c == tccw_pkg::CH_RVS_ON || c == tccw_pkg::CH_RVS_OFF ||
              c == tccw_pkg::CH_DOWN || c == tccw_pkg::CH_UP || c == tccw_pkg::CH_RIGHT ||
              c == tccw_pkg::CH_LEFT || ink[4]));
        stat.need_scroll = scroll_reg;
    end

    // cursor, mode and link update for the latched item
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        rvs_next = rvs_reg;
        ink_next = ink_reg;
        cont_next = cont_reg;
        wcode = to_cell(c, rvs_reg);
        if (!item_reg.action)
        begin
            case (c)
                tccw_pkg::CH_RETURN:
                begin
                    rvs_next = 1'b0;
                    col_next = '0;
                    if (row_reg != LAST_ROW) row_next = row_reg + 1'b1;
                    else
                    begin
                        cont_next = {1'b0, cont_reg[tccw_pkg::NUM_ROWS-1:1]};
                        cont_next[0] = 1'b0;
                    end
                    cont_next[row_next] = 1'b0;
                end
                tccw_pkg::CH_DELETE:
                begin
                    wcode = tccw_pkg::SPACE;
                    if (col_reg != '0) col_next = col_reg - 1'b1;
                    else if (row_reg != '0)
                    begin
                        row_next = row_reg - 1'b1;
                        col_next = LAST_COL;
                    end
                end
                tccw_pkg::CH_CLEAR:
                begin
                    cont_next = '0;
                    col_next = '0;
                    row_next = '0;
                    rvs_next = 1'b0;
                end
                tccw_pkg::CH_HOME:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                tccw_pkg::CH_RVS_ON: rvs_next = 1'b1;
                tccw_pkg::CH_RVS_OFF: rvs_next = 1'b0;
                tccw_pkg::CH_DOWN: if (row_reg != LAST_ROW) row_next = row_reg + 1'b1;
                tccw_pkg::CH_UP: if (row_reg != '0) row_next = row_reg - 1'b1;
                tccw_pkg::CH_RIGHT:
                begin
                    if (col_reg == LAST_COL)
                    begin
                        col_next = '0;
                        if (row_reg != LAST_ROW) row_next = row_reg + 1'b1;
                    end
                    else col_next = col_reg + 1'b1;
                end
                tccw_pkg::CH_LEFT:
                begin
                    if (col_reg == '0)
                    begin
                        col_next = LAST_COL;
                        if (row_reg != '0) row_next = row_reg - 1'b1;
                    end
                    else col_next = col_reg - 1'b1;
                end
                default:
                begin
                    if (ink[4]) ink_next = ink[3:0];
                    else if (col_reg != LAST_COL) col_next = col_reg + 1'b1;
                    else if (item_reg.from_keyboard && cont_reg[row_reg]) col_next = LAST_COL;
                    else
                    begin
                        col_next = '0;
                        if (row_reg != LAST_ROW)
                        begin
                            row_next = row_reg + 1'b1;
                            cont_next[row_next] = !cont_reg[row_reg];
                        end
                        else
                        begin
                            cont_next = {1'b0, cont_reg[tccw_pkg::NUM_ROWS-1:1]};
                            cont_next[0] = 1'b0;
                            cont_next[LAST_ROW] = !cont_reg[row_reg];
                        end
                    end
                end
            endcase
        end
    end

    logic scroll_now;
    assign scroll_now = !item_reg.action && row_reg == LAST_ROW
        && (c == tccw_pkg::CH_RETURN
            || (!ink[4] && stat.is_cell && c != tccw_pkg::CH_DELETE
                && col_reg == LAST_COL
                && !(item_reg.from_keyboard && cont_reg[row_reg])));

    logic [AW-1:0] cur_addr;
    assign cur_addr = AW'(wrow_reg) * ROW_STEP + AW'(wcol_reg);

    always_comb
    begin
        we = cmd.fill_wr || cmd.copy_wr || cmd.cell_wr;
        waddr = cmd.cell_wr ? cur_addr : cmd.addr;
        if (cmd.cell_wr) wdata = {wcode_reg, ink_reg};
        else if (cmd.copy_wr) wdata = rdata;
        else wdata = {tccw_pkg::SPACE, ink_reg};
        if (cmd.copy_rd) raddr = cmd.addr + ROW_STEP;
        else raddr = in_rng ? item_reg.cell_offset[AW-1:0] : '0;
    end

    tccw_ram #(.WIDTH(tccw_pkg::DW), .DEPTH(tccw_pkg::NUM_CELLS)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.out_load)
        begin
            out_item.cell_code <= in_rng ? rdata[11:4] : tccw_pkg::SPACE;
            out_item.cell_color <= in_rng ? rdata[3:0] : 4'd0;
            out_item.cursor_col <= 6'(col_reg);
            out_item.cursor_row <= 5'(row_reg);
            out_item.reverse_on <= rvs_reg;
            out_item.ink_color <= ink_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            rvs_reg <= 1'b0;
            ink_reg <= tccw_pkg::START_COLOR_RESET;
            cont_reg <= '0;
            scroll_reg <= 1'b0;
            wcol_reg <= '0;
            wrow_reg <= '0;
            wcode_reg <= tccw_pkg::SPACE;
        end
        else
        begin
            if (cfg_wr) ink_reg <= cfg_color;
            if (cmd.finish)
            begin
                // cell write goes to the cursor before the move, or after it for delete
                wrow_reg <= (c == tccw_pkg::CH_DELETE) ? row_next : row_reg;
                wcol_reg <= (c == tccw_pkg::CH_DELETE) ? col_next : col_reg;
                wcode_reg <= wcode;
                scroll_reg <= scroll_now;
                col_reg <= col_next;
                row_reg <= row_next;
                rvs_reg <= rvs_next;
                ink_reg <= ink_next;
                cont_reg <= cont_next;
            end
            if (cmd.scroll_fix)
            begin
                // the written cell moved up one row
                wrow_reg <= wrow_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/tccw_ctrl.sv @@
// controller: sequences decode, cell write, clear and scroll sweeps, read and result
`default_nettype none
module tccw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic               out_fire,
    input  wire tccw_pkg::dp_stat_t stat,
    output tccw_pkg::dp_cmd_t       cmd,
    output logic                    busy,
    output logic                    out_valid
);
    localparam int AW = tccw_pkg::AW;
    localparam logic [AW-1:0] LAST_CELL = AW'(tccw_pkg::NUM_CELLS - 1);
    localparam logic [AW-1:0] COPY_END = AW'(tccw_pkg::NUM_CELLS - tccw_pkg::NUM_COLS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DEC   = 9'b000000010,
        S_CLR   = 9'b000000100,
        S_WCELL = 9'b000001000,
        S_COPY  = 9'b000010000,
        S_COPYW = 9'b000100000,
        S_BLANK = 9'b001000000,
        S_READ  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        addr_next = addr_reg;
        ov_next = ov_reg;
        cmd = '0;
        cmd.addr = addr_reg;
        if (out_fire) ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.finish = 1'b1;
                addr_next = '0;
                if (stat.is_clear) state_next = S_CLR;
                else state_next = S_WCELL;
            end
            S_CLR:
            begin
                cmd.fill_wr = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_CELL) state_next = S_READ;
            end
            S_WCELL:
            begin
                cmd.cell_wr = stat.is_cell;
                addr_next = '0;
                state_next = stat.need_scroll ? S_COPY : S_READ;
            end
            S_COPY:
            begin
                cmd.copy_rd = 1'b1;
                state_next = S_COPYW;
            end
            S_COPYW:
            begin
                cmd.copy_wr = 1'b1;
                addr_next = addr_reg + 1'b1;
                state_next = (addr_reg == COPY_END - 1'b1) ? S_BLANK : S_COPY;
            end
            S_BLANK:
            begin
                cmd.fill_wr = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_CELL) state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_fire)
                begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            addr_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg <= addr_next;
            ov_reg <= ov_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/tccw_init.sv @@
// reset clearing pass over the screen store
`default_nettype none
module tccw_init (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    output logic                        active,
    output logic [tccw_pkg::AW-1:0]     addr
);
    localparam logic [tccw_pkg::AW-1:0] LAST_CELL = tccw_pkg::AW'(tccw_pkg::NUM_CELLS - 1);
    logic active_reg;
    logic [tccw_pkg::AW-1:0] addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            addr_reg <= '0;
        end
        else if (active_reg)
        begin
            addr_reg <= addr_reg + 1'b1;
            if (addr_reg == LAST_CELL) active_reg <= 1'b0;
        end
    end

    assign active = active_reg;
    assign addr = addr_reg;
endmodule
`default_nettype wire

@@ rtl/core/text_console_character_writer.sv @@
// top level: text console character writer with apb register port
// clear refills every cell; a scroll moves the rows up one (two accesses per moved cell) and blanks the last row
// the clear and blank sweeps run one cell a cycle through the single screen store
// after reset a clearing pass fills every cell of the store before any item is taken
// one item at a time; the next is taken once the result is registered
`default_nettype none
module text_console_character_writer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [1:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire tccw_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tccw_pkg::out_item_t      out_item
);
    tccw_pkg::dp_cmd_t  cmd, ctrl_cmd;
    tccw_pkg::dp_stat_t stat;
    logic busy, in_fire, out_fire, cfg_wr, init_active;
    logic [tccw_pkg::AW-1:0] init_addr;
    logic [3:0] start_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && paddr == tccw_pkg::REG_START_COLOR;
    assign prdata = (paddr == tccw_pkg::REG_START_COLOR) ? {28'd0, start_reg} : 32'd0;
    assign in_stall = busy || init_active;
    assign in_fire = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= tccw_pkg::START_COLOR_RESET;
        end
        else if (cfg_wr)
        begin
            start_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        cmd = ctrl_cmd;
        if (init_active)
        begin
            cmd.fill_wr = 1'b1;
            cmd.addr = init_addr;
        end
    end

    tccw_init u_init (.clk(clk), .rst_n(rst_n), .active(init_active), .addr(init_addr));

    tccw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .stat(stat), .cmd(ctrl_cmd), .busy(busy), .out_valid(out_valid)
    );

    tccw_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd),
        .cfg_wr(cfg_wr), .cfg_color(pwdata[3:0]), .stat(stat), .out_item(out_item)
    );
endmodule
`default_nettype wire

@@ test/text_console_character_writer_tb.sv @@
// testbench: drives console items and register writes, predicts each result, checks it
`default_nettype none
module text_console_character_writer_tb;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int NUM_COLS = tccw_pkg::NUM_COLS;
    localparam int NUM_ROWS = tccw_pkg::NUM_ROWS;
    localparam int NUM_CELLS = tccw_pkg::NUM_CELLS;
    localparam logic [7:0] CH_RETURN = tccw_pkg::CH_RETURN;
    localparam logic [7:0] CH_DELETE = tccw_pkg::CH_DELETE;
    localparam logic [7:0] CH_CLEAR = tccw_pkg::CH_CLEAR;
    localparam logic [7:0] CH_HOME = tccw_pkg::CH_HOME;
    localparam logic [7:0] CH_RVS_ON = tccw_pkg::CH_RVS_ON;
    localparam logic [7:0] CH_RVS_OFF = tccw_pkg::CH_RVS_OFF;
    localparam logic [7:0] CH_DOWN = tccw_pkg::CH_DOWN;
    localparam logic [7:0] CH_UP = tccw_pkg::CH_UP;
    localparam logic [7:0] CH_RIGHT = tccw_pkg::CH_RIGHT;
    localparam logic [7:0] CH_LEFT = tccw_pkg::CH_LEFT;
    localparam logic [7:0] RVS_BIT = tccw_pkg::RVS_BIT;
    localparam logic [7:0] SPACE = tccw_pkg::SPACE;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_stall;
    tccw_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    tccw_pkg::out_item_t out_item;

    text_console_character_writer dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    // console model state
    logic [7:0] scr_code [NUM_CELLS];
    logic [3:0] scr_color [NUM_CELLS];
    logic row_link [NUM_ROWS];
    int col_pos;
    int row_pos;
    logic rvs_mode;
    logic [3:0] ink;
    logic [3:0] start_ink;

    tccw_pkg::in_item_t pending_items[$];
    tccw_pkg::out_item_t expected_cells[$];
    int send_idle_pct;
    int stall_pct;
    int mismatches;
    int idle_cycles;
    bit hold_sender;
    logic in_taken;

    function automatic int ink_of(input logic [7:0] c);
        case (c)
            8'd144: return 0;  8'd5: return 1;    8'd28: return 2;   8'd159: return 3;
            8'd156: return 4;  8'd30: return 5;   8'd31: return 6;   8'd158: return 7;
            8'd129: return 8;  8'd149: return 9;  8'd150: return 10; 8'd151: return 11;
            8'd152: return 12; 8'd153: return 13; 8'd154: return 14; 8'd155: return 15;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] screen_code_of(input logic [7:0] c);
        if (c < 8'h20) return c + 8'h80;
        if (c < 8'h40) return c;
        if (c < 8'h60) return c - 8'h40;
        if (c < 8'h80) return c - 8'h20;
        if (c < 8'hA0) return c + 8'h40;
        if (c < 8'hC0) return c - 8'h40;
        if (c < 8'hFF) return c - 8'h80;
        return 8'h5E;
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            scr_code[i] = SPACE;
            scr_color[i] = ink;
        end
        for (int i = 0; i < NUM_ROWS; i++)
            row_link[i] = 1'b0;
        col_pos = 0;
        row_pos = 0;
        rvs_mode = 1'b0;
    endfunction

    function automatic void place_cursor(input int x, input int y);
        col_pos = x < 0 ? 0 : (x >= NUM_COLS ? NUM_COLS - 1 : x);
        row_pos = y < 0 ? 0 : (y >= NUM_ROWS ? NUM_ROWS - 1 : y);
    endfunction

    function automatic void put_cell(input logic [7:0] code);
        int i;
        i = row_pos * NUM_COLS + col_pos;
        scr_code[i] = code;
        scr_color[i] = ink;
    endfunction

    function automatic void new_line();
        col_pos = 0;
        row_pos++;
        if (row_pos >= NUM_ROWS)
        begin
            for (int i = 0; i < (NUM_ROWS - 1) * NUM_COLS; i++)
            begin
                scr_code[i] = scr_code[i + NUM_COLS];
                scr_color[i] = scr_color[i + NUM_COLS];
            end
            for (int i = 0; i < NUM_COLS; i++)
            begin
                scr_code[(NUM_ROWS - 1) * NUM_COLS + i] = SPACE;
                scr_color[(NUM_ROWS - 1) * NUM_COLS + i] = ink;
            end
            for (int i = 0; i < NUM_ROWS - 1; i++)
                row_link[i] = row_link[i + 1];
            row_link[NUM_ROWS - 1] = 1'b0;
            row_link[0] = 1'b0;
            row_pos = NUM_ROWS - 1;
        end
        row_link[row_pos] = 1'b0;
    endfunction

    function automatic void apply_byte(input logic [7:0] c, input logic kbd);
        int k;
        logic link;
        case (c)
            CH_RETURN:
            begin
                rvs_mode = 1'b0;
                new_line();
            end
            CH_DELETE:
            begin
                if (col_pos > 0)
                    col_pos--;
                else if (row_pos > 0)
                begin
                    row_pos--;
                    col_pos = NUM_COLS - 1;
                end
                put_cell(SPACE);
            end
            CH_CLEAR: blank_screen();
            CH_HOME:
            begin
                col_pos = 0;
                row_pos = 0;
            end
            CH_RVS_ON: rvs_mode = 1'b1;
            CH_RVS_OFF: rvs_mode = 1'b0;
            CH_DOWN: place_cursor(col_pos, row_pos + 1);
            CH_UP: place_cursor(col_pos, row_pos - 1);
            CH_RIGHT:
                if (col_pos + 1 >= NUM_COLS)
                    place_cursor(0, row_pos + 1);
                else
                    place_cursor(col_pos + 1, row_pos);
            CH_LEFT:
                if (col_pos == 0)
                    place_cursor(NUM_COLS - 1, row_pos - 1);
                else
                    place_cursor(col_pos - 1, row_pos);
            default:
            begin
                k = ink_of(c);
                if (k >= 0)
                    ink = k[3:0];
                else
                begin
                    put_cell(screen_code_of(c) | (rvs_mode ? RVS_BIT : 8'h00));
                    col_pos++;
                    if (col_pos >= NUM_COLS)
                    begin
                        if (kbd && row_link[row_pos])
                            col_pos = NUM_COLS - 1;
                        else
                        begin
                            link = !row_link[row_pos];
                            new_line();
                            row_link[row_pos] = link;
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic tccw_pkg::out_item_t console_result(input tccw_pkg::in_item_t it);
        tccw_pkg::out_item_t r;
        if (!it.action)
            apply_byte(it.char_code, it.from_keyboard);
        if (it.cell_offset < NUM_CELLS)
        begin
            r.cell_code = scr_code[it.cell_offset];
            r.cell_color = scr_color[it.cell_offset];
        end
        else
        begin
            r.cell_code = SPACE;
            r.cell_color = 4'd0;
        end
        r.cursor_col = col_pos[5:0];
        r.cursor_row = row_pos[4:0];
        r.reverse_on = rvs_mode;
        r.ink_color = ink;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() > 0 && !hold_sender
                        && $urandom_range(99) >= send_idle_pct)
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall)
                expected_cells.push_back(console_result(in_item));
            if (out_valid && !out_stall)
            begin
                if (expected_cells.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item %p", out_item);
                end
                else
                begin
                    tccw_pkg::out_item_t e;
                    e = expected_cells.pop_front();
                    if (out_item !== e)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch expected %p actual %p", e, out_item);
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [3:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {tccw_pkg::REG_START_COLOR[1:0]};
        pwdata <= {28'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        start_ink = v;
        ink = v;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_cells.size() > 0 || in_valid)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic add_item(input logic a, input logic [7:0] c, input logic k,
                            input logic [9:0] off);
        tccw_pkg::in_item_t it;
        it.action = a;
        it.char_code = c;
        it.from_keyboard = k;
        it.cell_offset = off;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] ctl [10];
        int r;
        ctl = '{CH_RETURN, CH_DELETE, CH_CLEAR, CH_HOME, CH_RVS_ON, CH_RVS_OFF,
                CH_DOWN, CH_UP, CH_RIGHT, CH_LEFT};
        r = $urandom_range(99);
        if (r < 70)
            return 8'($urandom_range(8'h20, 8'h7F));
        if (r < 71)
            return CH_CLEAR;
        if (r < 85)
            return ctl[$urandom_range(9)];
        return 8'($urandom_range(255));
    endfunction

    task automatic random_block(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 15)
                add_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         10'($urandom_range(r < 2 ? 1023 : NUM_CELLS - 1)));
            else
                add_item(1'b0, pick_byte(), 1'($urandom_range(1)),
                         r < 18 ? 10'($urandom_range(1023)) :
                         10'((NUM_ROWS - 1) * NUM_COLS + $urandom_range(NUM_COLS * 2)
                             - NUM_COLS));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_item = '0;
        in_taken = 1'b0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        idle_cycles = 0;
        hold_sender = 1'b0;
        start_ink = tccw_pkg::START_COLOR_RESET;
        ink = start_ink;
        blank_screen();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: controls, edges, wraps
        add_item(1'b1, 8'h00, 1'b0, 10'd0);
        add_item(1'b1, 8'h00, 1'b0, 10'd1023);
        add_item(1'b0, CH_DELETE, 1'b0, 10'd0);
        add_item(1'b0, CH_LEFT, 1'b0, 10'd0);
        add_item(1'b0, CH_UP, 1'b0, 10'd0);
        add_item(1'b0, 8'hFF, 1'b1, 10'd39);
        add_item(1'b0, CH_RVS_ON, 1'b0, 10'd0);
        add_item(1'b0, 8'h41, 1'b0, 10'd0);
        add_item(1'b0, 8'h05, 1'b0, 10'd1);
        add_item(1'b0, 8'h00, 1'b0, 10'd1);
        add_item(1'b0, CH_RVS_OFF, 1'b0, 10'd999);
        add_item(1'b0, CH_HOME, 1'b0, 10'd1000);
        add_item(1'b0, CH_DOWN, 1'b0, 10'd0);
        add_item(1'b0, CH_RIGHT, 1'b0, 10'd0);
        add_item(1'b0, 8'h90, 1'b0, 10'd0);
        add_item(1'b0, CH_RETURN, 1'b1, 10'd0);
        add_item(1'b0, CH_CLEAR, 1'b0, 10'd0);
        for (int i = 0; i < 40; i++)
            add_item(1'b0, CH_RIGHT, 1'b0, 10'd0);
        for (int i = 0; i < 30; i++)
            add_item(1'b0, CH_DOWN, 1'b0, 10'd0);
        add_item(1'b0, CH_RIGHT, 1'b0, 10'd999);
        add_item(1'b0, CH_LEFT, 1'b0, 10'd999);
        // keyboard line cap, then wrap and scroll
        for (int i = 0; i < 85; i++)
            add_item(1'b0, 8'h20 + i[7:0] % 64, 1'b1, 10'd999);
        for (int i = 0; i < 85; i++)
            add_item(1'b0, 8'hC0 + i[7:0] % 63, 1'b0, 10'd960);
        // return on the last row scrolls
        add_item(1'b0, CH_RETURN, 1'b0, 10'd920);
        add_item(1'b0, CH_RETURN, 1'b0, 10'd960);
        drain();

        reg_write(4'd15);
        random_block(85);
        drain();

        send_idle_pct = 72;
        reg_write(4'd0);
        random_block(85);
        drain();

        reg_write(4'd7);
        send_idle_pct = 0;
        stall_pct = 72;
        random_block(85);
        while (pending_items.size() > 40)
            @(posedge clk);
        hold_sender = 1'b1;
        while (expected_cells.size() > 0 || in_valid)
            @(posedge clk);
        hold_sender = 1'b0;
        drain();

        send_idle_pct = 19;
        stall_pct = 19;
        random_block(85);
        drain();

        if (mismatches == 0 && expected_cells.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
